### hw/rtl/dmsr_pkg.sv
// ---------------------------------------------------------------------------
// dmsr_pkg: shared definitions of the dual motor speed ramp
// Widths, reset values, opcode and register codes, control and status
// structs between the lanes and the sequencer, and small helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package dmsr_pkg;

   // field widths
   localparam int SPEED_W     = 7;
   localparam int STEP_W      = 7;
   localparam int CFG_DELAY_W = 16;
   localparam int PERIOD_W    = 32;
   localparam int APB_ADDR_W  = 5;
   localparam int APB_DATA_W  = 32;

   // ramp and wait counters
   localparam int DELAY_BITS = 16;
   localparam logic [31:0] DELAY_LIM = 32'((64'd1 << DELAY_BITS) - 64'd1);

   localparam logic [SPEED_W-1:0] FULL_SPEED = 7'd100;

   // duty = q * speed + ((r * RECIP * speed) >> RECIP_SHIFT), period = 100 * q + r
   localparam int DUTY_Q_W    = 26;
   localparam int DUTY_RK_W   = 19;
   localparam int RECIP       = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RK_PROD_W   = DUTY_RK_W + SPEED_W;
   localparam int PCT_DIV     = 100;
   localparam int REM_W       = 7;

   // period / 100 as (period * PCT_RECIP) >> PCT_RECIP_SHIFT, exact for any 32-bit period
   localparam logic [PERIOD_W-1:0] PCT_RECIP       = 32'd1374389535;
   localparam int                  PCT_RECIP_SHIFT = 37;

   // register reset values
   localparam logic [STEP_W-1:0]      RST_ACCEL_STEP   = 7'd10;
   localparam logic [CFG_DELAY_W-1:0] RST_ACCEL_DELAY  = 16'd100;
   localparam logic [STEP_W-1:0]      RST_BRAKE_STEP   = 7'd10;
   localparam logic [CFG_DELAY_W-1:0] RST_BRAKE_DELAY  = 16'd100;
   localparam logic [CFG_DELAY_W-1:0] RST_START_DELAY  = 16'd10;
   localparam logic [CFG_DELAY_W-1:0] RST_REVERSE_WAIT = 16'd100;
   localparam logic [PERIOD_W-1:0]    RST_PWM_PERIOD   = 32'd1000000;
   localparam logic [DUTY_Q_W-1:0]    RST_DUTY_Q       = DUTY_Q_W'(RST_PWM_PERIOD / PCT_DIV);
   localparam logic [DUTY_RK_W-1:0]   RST_DUTY_RK      =
      DUTY_RK_W'((RST_PWM_PERIOD % PCT_DIV) * RECIP);

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET  = 2'd1,
      OP_STOP = 2'd2,
      OP_NOP  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_ACCEL_STEP   = 3'd0,
      REG_ACCEL_DELAY  = 3'd1,
      REG_BRAKE_STEP   = 3'd2,
      REG_BRAKE_DELAY  = 3'd3,
      REG_START_DELAY  = 3'd4,
      REG_REVERSE_WAIT = 3'd5,
      REG_PWM_PERIOD   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [STEP_W-1:0]      accel_step;
      logic [CFG_DELAY_W-1:0] accel_delay;
      logic [STEP_W-1:0]      brake_step;
      logic [CFG_DELAY_W-1:0] brake_delay;
      logic [CFG_DELAY_W-1:0] start_delay;
      logic [CFG_DELAY_W-1:0] reverse_wait;
      logic [DUTY_Q_W-1:0]    duty_q;
      logic [DUTY_RK_W-1:0]   duty_rk;
   } cfg_type;

   // sequencer to lane
   typedef struct packed {
      logic tick;
      logic set_cmd;
      logic any_rev;
      logic stop;
      logic flip;
   } lane_ctrl_type;

   // lane to sequencer / output pipeline
   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic               dir;
      logic [SPEED_W-1:0] speed_tick;
      logic               needs_rev;
      logic               mismatch;
   } lane_stat_type;

   // zero counts as one tick, saturate to the counter width
   function automatic logic [DELAY_BITS-1:0] delay_load(input logic [CFG_DELAY_W-1:0] d);
      logic [31:0] v;
      v = 32'(d);
      if (v == 32'd0) v = 32'd1;
      if (v > DELAY_LIM) v = DELAY_LIM;
      return v[DELAY_BITS-1:0];
   endfunction

   function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s);
      return (s > FULL_SPEED) ? FULL_SPEED : s;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/dmsr_if.sv
// ---------------------------------------------------------------------------
// dmsr_if: valid/ready channels of the dual motor speed ramp
// Request channel (opcode and per-motor command) and response channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface dmsr_req_if
   import dmsr_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [SPEED_W-1:0] speed_a;
   logic [SPEED_W-1:0] speed_b;
   logic               dir_a;
   logic               dir_b;

   modport source (output valid, opcode, speed_a, speed_b, dir_a, dir_b, input ready);
   modport sink   (input valid, opcode, speed_a, speed_b, dir_a, dir_b, output ready);
endinterface

interface dmsr_rsp_if
   import dmsr_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [SPEED_W-1:0]  cur_speed_a;
   logic [SPEED_W-1:0]  cur_speed_b;
   logic                cur_dir_a;
   logic                cur_dir_b;
   logic [PERIOD_W-1:0] duty_a;
   logic [PERIOD_W-1:0] duty_b;
   logic                accepted;
   logic                busy_res;

   modport source (output valid, cur_speed_a, cur_speed_b, cur_dir_a, cur_dir_b,
                   duty_a, duty_b, accepted, busy_res, input ready);
   modport sink   (input valid, cur_speed_a, cur_speed_b, cur_dir_a, cur_dir_b,
                   duty_a, duty_b, accepted, busy_res, output ready);
endinterface

`default_nettype wire

### hw/rtl/dual_motor_speed_ramp.sv
// ---------------------------------------------------------------------------
// dual_motor_speed_ramp: two-motor speed ramp generator
// Request beats carry a tick, a set command for both motors, a stop or a no-op; each
// request beat yields one response beat with speeds, directions, PWM duty
// and status after the update.
//
// Channels: req_in (valid/ready sink), rsp_out (valid/ready source), and an
// APB-style register port (psel/penable/pwrite/paddr/pwdata/prdata/pready).
// A request beat accepted on req_in passes the lane state, the duty products
// and the duty sum registers before its response beat is valid.
// Throughput: one beat per cycle while rsp_out is ready and no period
// division runs; the three-stage result pipeline holds while rsp_out is
// stalled, and req_in.ready follows the pipeline enable. A write of the PWM
// period starts a divide by 100 by reciprocal multiplication; req_in.ready
// is low until that division is done.
// Reset: registers take their default values, both motors stand still in
// direction zero with no target, the direction change sequencer is idle and
// the result pipeline is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_motor_speed_ramp
   import dmsr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   dmsr_req_if.sink                   req_in,
   dmsr_rsp_if.source                 rsp_out,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output      logic [APB_DATA_W-1:0] prdata,
   output      logic                  pready
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_BRAKE = 2'd1,
      PH_WAIT  = 2'd2
   } phase_type;

   cfg_type               cfg;
   logic                  div_busy;
   lane_ctrl_type         ctrl;
   lane_stat_type         stat_a, stat_b;

   phase_type             phase_ff, phase_in;
   logic [DELAY_BITS-1:0] count_ff, count_in;
   logic [DELAY_BITS-1:0] count_dec;

   logic                  en;
   logic                  acc;
   opcode_type            op;
   logic                  phase_idle;
   logic                  still;
   logic                  flip;

   // result pipeline: stage 1 is the lane state itself
   logic                  v1_ff, v2_ff, v3_ff;
   logic                  acc1_ff;
   logic [SPEED_W-1:0]    spd_a2_ff, spd_b2_ff, spd_a3_ff, spd_b3_ff;
   logic                  dir_a2_ff, dir_b2_ff, dir_a3_ff, dir_b3_ff;
   logic                  acc2_ff, acc3_ff, busy2_ff, busy3_ff;

   dmsr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .div_busy (div_busy)
   );

   // handshake
   assign en           = !v3_ff || rsp_out.ready;
   assign req_in.ready = en && !div_busy;
   assign acc          = req_in.valid && req_in.ready;
   assign op           = opcode_type'(req_in.opcode);

   // opcode decode
   assign phase_idle = (phase_ff != PH_BRAKE) && (phase_ff != PH_WAIT);
   always_comb begin
      ctrl.tick    = acc && (op == OP_TICK);
      ctrl.set_cmd = acc && (op == OP_SET) && phase_idle;
      ctrl.stop    = acc && (op == OP_STOP);
      ctrl.any_rev = stat_a.mismatch || stat_b.mismatch;
      ctrl.flip    = flip;
   end

   dmsr_lane u_lane_a (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctrl      (ctrl),
      .req_speed (req_in.speed_a),
      .req_dir   (req_in.dir_a),
      .stat      (stat_a)
   );

   dmsr_lane u_lane_b (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctrl      (ctrl),
      .req_speed (req_in.speed_b),
      .req_dir   (req_in.dir_b),
      .stat      (stat_b)
   );

   // merge: every reversing motor at standstill after this tick's step
   assign still = (!stat_a.needs_rev || stat_a.speed_tick == '0) &&
                  (!stat_b.needs_rev || stat_b.speed_tick == '0);

   // direction change sequencer
   assign count_dec = (count_ff != '0) ? (count_ff - DELAY_BITS'(1)) : count_ff;
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      flip     = 1'b0;
      case (phase_ff)
         PH_BRAKE: begin
            if (ctrl.tick && still) begin
               phase_in = PH_WAIT;
               count_in = delay_load(cfg.reverse_wait);
            end
         end
         PH_WAIT: begin
            if (ctrl.tick) begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  flip     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (ctrl.set_cmd && ctrl.any_rev) phase_in = PH_BRAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= acc;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (en) begin
         acc1_ff   <= ctrl.set_cmd || ctrl.stop;
         spd_a2_ff <= stat_a.speed;
         spd_b2_ff <= stat_b.speed;
         dir_a2_ff <= stat_a.dir;
         dir_b2_ff <= stat_b.dir;
         acc2_ff   <= acc1_ff;
         busy2_ff  <= (phase_ff != PH_IDLE);
         spd_a3_ff <= spd_a2_ff;
         spd_b3_ff <= spd_b2_ff;
         dir_a3_ff <= dir_a2_ff;
         dir_b3_ff <= dir_b2_ff;
         acc3_ff   <= acc2_ff;
         busy3_ff  <= busy2_ff;
      end
   end

   dmsr_duty u_duty_a (
      .clock   (clock),
      .en      (en),
      .speed   (stat_a.speed),
      .duty_q  (cfg.duty_q),
      .duty_rk (cfg.duty_rk),
      .duty    (rsp_out.duty_a)
   );

   dmsr_duty u_duty_b (
      .clock   (clock),
      .en      (en),
      .speed   (stat_b.speed),
      .duty_q  (cfg.duty_q),
      .duty_rk (cfg.duty_rk),
      .duty    (rsp_out.duty_b)
   );

   assign rsp_out.valid       = v3_ff;
   assign rsp_out.cur_speed_a = spd_a3_ff;
   assign rsp_out.cur_speed_b = spd_b3_ff;
   assign rsp_out.cur_dir_a   = dir_a3_ff;
   assign rsp_out.cur_dir_b   = dir_b3_ff;
   assign rsp_out.accepted    = acc3_ff;
   assign rsp_out.busy_res    = busy3_ff;

endmodule

`default_nettype wire

### hw/rtl/dmsr_csr.sv
// ---------------------------------------------------------------------------
// dmsr_csr: register file and PWM period divider
// APB-style writes and reads; a period write starts a division
// by 100 (reciprocal multiply, remainder, scaling) that yields the quotient
// and scaled remainder used for duty.
// ---------------------------------------------------------------------------
`default_nettype none

module dmsr_csr
   import dmsr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output      logic [APB_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      cfg_type               cfg,
   output      logic                  div_busy
);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_MUL,
      DV_REM,
      DV_DONE
   } dv_state_type;

   logic [STEP_W-1:0]      accel_step_ff;
   logic [CFG_DELAY_W-1:0] accel_delay_ff;
   logic [STEP_W-1:0]      brake_step_ff;
   logic [CFG_DELAY_W-1:0] brake_delay_ff;
   logic [CFG_DELAY_W-1:0] start_delay_ff;
   logic [CFG_DELAY_W-1:0] reverse_wait_ff;
   logic [PERIOD_W-1:0]    pwm_period_ff;

   dv_state_type           dv_state_ff;
   logic [DUTY_Q_W-1:0]    dv_q_ff;
   logic [REM_W-1:0]       dv_rem_ff;
   logic [DUTY_Q_W-1:0]    duty_q_ff;
   logic [DUTY_RK_W-1:0]   duty_rk_ff;

   logic                   wr_en;
   reg_index_type          wr_idx;
   logic [2*PERIOD_W-1:0]  recip_prod;
   logic [PERIOD_W-1:0]    q_times_pct;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign wr_idx = reg_index_type'(paddr[APB_ADDR_W-1:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_step_ff   <= RST_ACCEL_STEP;
         accel_delay_ff  <= RST_ACCEL_DELAY;
         brake_step_ff   <= RST_BRAKE_STEP;
         brake_delay_ff  <= RST_BRAKE_DELAY;
         start_delay_ff  <= RST_START_DELAY;
         reverse_wait_ff <= RST_REVERSE_WAIT;
         pwm_period_ff   <= RST_PWM_PERIOD;
      end else if (wr_en) begin
         case (wr_idx)
            REG_ACCEL_STEP:   accel_step_ff   <= pwdata[STEP_W-1:0];
            REG_ACCEL_DELAY:  accel_delay_ff  <= pwdata[CFG_DELAY_W-1:0];
            REG_BRAKE_STEP:   brake_step_ff   <= pwdata[STEP_W-1:0];
            REG_BRAKE_DELAY:  brake_delay_ff  <= pwdata[CFG_DELAY_W-1:0];
            REG_START_DELAY:  start_delay_ff  <= pwdata[CFG_DELAY_W-1:0];
            REG_REVERSE_WAIT: reverse_wait_ff <= pwdata[CFG_DELAY_W-1:0];
            REG_PWM_PERIOD:   pwm_period_ff   <= pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (wr_idx)
         REG_ACCEL_STEP:   prdata = APB_DATA_W'(accel_step_ff);
         REG_ACCEL_DELAY:  prdata = APB_DATA_W'(accel_delay_ff);
         REG_BRAKE_STEP:   prdata = APB_DATA_W'(brake_step_ff);
         REG_BRAKE_DELAY:  prdata = APB_DATA_W'(brake_delay_ff);
         REG_START_DELAY:  prdata = APB_DATA_W'(start_delay_ff);
         REG_REVERSE_WAIT: prdata = APB_DATA_W'(reverse_wait_ff);
         REG_PWM_PERIOD:   prdata = APB_DATA_W'(pwm_period_ff);
         default:          prdata = '0;
      endcase
   end

   // quotient by reciprocal multiply, remainder by back-multiply and subtract
   assign recip_prod  = (2*PERIOD_W)'(pwm_period_ff) * (2*PERIOD_W)'(PCT_RECIP);
   assign q_times_pct = PERIOD_W'(dv_q_ff) * PERIOD_W'(PCT_DIV);

   // divider sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_state_ff <= DV_IDLE;
         dv_q_ff     <= '0;
         dv_rem_ff   <= '0;
         duty_q_ff   <= RST_DUTY_Q;
         duty_rk_ff  <= RST_DUTY_RK;
      end else if (wr_en && wr_idx == REG_PWM_PERIOD) begin
         dv_state_ff <= DV_MUL;
      end else begin
         case (dv_state_ff)
            DV_MUL: begin
               dv_q_ff     <= DUTY_Q_W'(recip_prod >> PCT_RECIP_SHIFT);
               dv_state_ff <= DV_REM;
            end
            DV_REM: begin
               dv_rem_ff   <= REM_W'(pwm_period_ff - q_times_pct);
               dv_state_ff <= DV_DONE;
            end
            DV_DONE: begin
               duty_q_ff   <= dv_q_ff;
               duty_rk_ff  <= DUTY_RK_W'(dv_rem_ff * RECIP);
               dv_state_ff <= DV_IDLE;
            end
            default: dv_state_ff <= DV_IDLE;
         endcase
      end
   end

   assign div_busy = (dv_state_ff != DV_IDLE);

   always_comb begin
      cfg.accel_step   = accel_step_ff;
      cfg.accel_delay  = accel_delay_ff;
      cfg.brake_step   = brake_step_ff;
      cfg.brake_delay  = brake_delay_ff;
      cfg.start_delay  = start_delay_ff;
      cfg.reverse_wait = reverse_wait_ff;
      cfg.duty_q       = duty_q_ff;
      cfg.duty_rk      = duty_rk_ff;
   end

endmodule

`default_nettype wire

### hw/rtl/dmsr_lane.sv
// ---------------------------------------------------------------------------
// dmsr_lane: ramp state of one motor
// Speed, target, direction, step timer and pending command of one motor,
// updated from the opcode decode and the shared direction change sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module dmsr_lane
   import dmsr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire lane_ctrl_type      ctrl,
   input  wire logic [SPEED_W-1:0] req_speed,
   input  wire logic               req_dir,
   output      lane_stat_type      stat
);

   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic [SPEED_W-1:0]    target_ff, target_in;
   logic                  dir_ff, dir_in;
   logic [DELAY_BITS-1:0] timer_ff, timer_in;
   logic [SPEED_W-1:0]    pend_speed_ff, pend_speed_in;
   logic                  pend_dir_ff, pend_dir_in;
   logic                  needs_rev_ff, needs_rev_in;

   logic [SPEED_W-1:0]    diff_up, diff_dn;
   logic [SPEED_W-1:0]    step_spd;
   logic [SPEED_W-1:0]    tick_spd;
   logic [DELAY_BITS-1:0] tick_tmr;
   logic [DELAY_BITS-1:0] tmr_dec;
   logic [SPEED_W-1:0]    req_clamped;
   logic                  mismatch;
   logic                  do_tgt;
   logic [SPEED_W-1:0]    tgt_val;

   assign req_clamped = clamp_speed(req_speed);
   assign mismatch    = (dir_ff != req_dir);

   // one ramp step toward the target
   assign diff_up = target_ff - speed_ff;
   assign diff_dn = speed_ff - target_ff;
   always_comb begin
      if (speed_ff < target_ff)
         step_spd = speed_ff + ((cfg.accel_step < diff_up) ? cfg.accel_step : diff_up);
      else if (speed_ff > target_ff)
         step_spd = speed_ff - ((cfg.brake_step < diff_dn) ? cfg.brake_step : diff_dn);
      else
         step_spd = speed_ff;
   end

   // timer countdown, step on expiry and re-arm
   assign tmr_dec = timer_ff - DELAY_BITS'(1);
   always_comb begin
      tick_spd = speed_ff;
      tick_tmr = timer_ff;
      if (timer_ff != '0) begin
         tick_tmr = tmr_dec;
         if (tmr_dec == '0) begin
            tick_spd = step_spd;
            if (step_spd < target_ff)      tick_tmr = delay_load(cfg.accel_delay);
            else if (step_spd > target_ff) tick_tmr = delay_load(cfg.brake_delay);
            else                           tick_tmr = '0;
         end
      end
   end

   // new target selection
   always_comb begin
      do_tgt  = 1'b0;
      tgt_val = '0;
      if (ctrl.flip) begin
         do_tgt  = 1'b1;
         tgt_val = pend_speed_ff;
      end else if (ctrl.set_cmd && !ctrl.any_rev) begin
         do_tgt  = 1'b1;
         tgt_val = req_clamped;
      end else if (ctrl.set_cmd && mismatch) begin
         do_tgt  = 1'b1;
      end else if (ctrl.stop) begin
         do_tgt  = 1'b1;
      end
   end

   // next state
   always_comb begin
      speed_in      = speed_ff;
      target_in     = target_ff;
      dir_in        = dir_ff;
      timer_in      = timer_ff;
      pend_speed_in = pend_speed_ff;
      pend_dir_in   = pend_dir_ff;
      needs_rev_in  = needs_rev_ff;
      if (ctrl.tick) begin
         speed_in = tick_spd;
         timer_in = tick_tmr;
      end
      if (do_tgt && target_ff != tgt_val) begin
         target_in = tgt_val;
         timer_in  = delay_load(cfg.start_delay);
      end
      if (ctrl.set_cmd) begin
         needs_rev_in = mismatch;
         if (ctrl.any_rev) begin
            pend_speed_in = req_clamped;
            pend_dir_in   = req_dir;
         end
      end
      if (ctrl.stop) pend_speed_in = '0;
      if (ctrl.flip) begin
         needs_rev_in = 1'b0;
         if (needs_rev_ff) dir_in = pend_dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff      <= '0;
         target_ff     <= '0;
         dir_ff        <= 1'b0;
         timer_ff      <= '0;
         pend_speed_ff <= '0;
         pend_dir_ff   <= 1'b0;
         needs_rev_ff  <= 1'b0;
      end else begin
         speed_ff      <= speed_in;
         target_ff     <= target_in;
         dir_ff        <= dir_in;
         timer_ff      <= timer_in;
         pend_speed_ff <= pend_speed_in;
         pend_dir_ff   <= pend_dir_in;
         needs_rev_ff  <= needs_rev_in;
      end
   end

   always_comb begin
      stat.speed      = speed_ff;
      stat.dir        = dir_ff;
      stat.speed_tick = tick_spd;
      stat.needs_rev  = needs_rev_ff;
      stat.mismatch   = mismatch;
   end

endmodule

`default_nettype wire

### hw/rtl/dmsr_duty.sv
// ---------------------------------------------------------------------------
// dmsr_duty: PWM duty pipeline of one motor
// Two stages: products of speed with the period quotient and the scaled
// remainder, then the sum. Advances only when the pipeline enable is high.
// ---------------------------------------------------------------------------
`default_nettype none

module dmsr_duty
   import dmsr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [SPEED_W-1:0]   speed,
   input  wire logic [DUTY_Q_W-1:0]  duty_q,
   input  wire logic [DUTY_RK_W-1:0] duty_rk,
   output      logic [PERIOD_W-1:0]  duty
);

   logic [PERIOD_W-1:0]              prod_q;
   logic [RK_PROD_W-1:0]             prod_r;
   logic [PERIOD_W-1:0]              whole_ff;
   logic [RK_PROD_W-RECIP_SHIFT-1:0] frac_ff;
   logic [PERIOD_W-1:0]              duty_ff;

   // whole part never exceeds the period, so it fits the duty width
   assign prod_q = PERIOD_W'(duty_q) * PERIOD_W'(speed);
   assign prod_r = RK_PROD_W'(duty_rk) * RK_PROD_W'(speed);

   always_ff @(posedge clock) begin
      if (en) begin
         whole_ff <= prod_q;
         frac_ff  <= prod_r[RK_PROD_W-1:RECIP_SHIFT];
         duty_ff  <= whole_ff + PERIOD_W'(frac_ff);
      end
   end

   assign duty = duty_ff;

endmodule

`default_nettype wire
